// File: rtl/core/three_phase_section_pixel_top_assert.svh
// Assertion macros shared by the checkers of the sectioning block.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef THREE_PHASE_SECTION_PIXEL_TOP_ASSERT_SVH
`define THREE_PHASE_SECTION_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TPSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tpsp_pkg.sv
`default_nettype none

package tpsp_pkg;

    // Width of every pixel field at the ports.
    localparam int FIELD_BITS = 16;

    // Default width of the pixel datapath.
    localparam int PIXEL_BITS_DEF = 16;

endpackage

`default_nettype wire

// File: rtl/core/tpsp_diff_sq.sv
`default_nettype none

// Three-stage front end: absolute differences, squares, exact sum.
module tpsp_diff_sq #(
    parameter int PIXEL_BITS = tpsp_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                valid,
    input  wire logic [tpsp_pkg::FIELD_BITS-1:0]     p0,
    input  wire logic [tpsp_pkg::FIELD_BITS-1:0]     p1,
    input  wire logic [tpsp_pkg::FIELD_BITS-1:0]     p2,
    output logic                                     sum_valid,
    output logic [2*PIXEL_BITS+1:0]                  sum
);
    import tpsp_pkg::*;

    localparam int PB = PIXEL_BITS;
    localparam int SW = 2 * PIXEL_BITS + 2;

    logic [PB-1:0]   a0;
    logic [PB-1:0]   a1;
    logic [PB-1:0]   a2;
    logic [PB-1:0]   d01_next;
    logic [PB-1:0]   d12_next;
    logic [PB-1:0]   d20_next;
    logic [PB-1:0]   d01_reg;
    logic [PB-1:0]   d12_reg;
    logic [PB-1:0]   d20_reg;
    logic [2*PB-1:0] s01_reg;
    logic [2*PB-1:0] s12_reg;
    logic [2*PB-1:0] s20_reg;
    logic [SW-1:0]   sum_next;
    logic [SW-1:0]   sum_reg;
    logic            v_diff_reg;
    logic            v_sq_reg;
    logic            v_sum_reg;

    // Drop the bits above the datapath width
    assign a0 = p0[PB-1:0];
    assign a1 = p1[PB-1:0];
    assign a2 = p2[PB-1:0];

    // Form the absolute pairwise differences
    assign d01_next = (a0 > a1) ? (a0 - a1) : (a1 - a0);
    assign d12_next = (a1 > a2) ? (a1 - a2) : (a2 - a1);
    assign d20_next = (a2 > a0) ? (a2 - a0) : (a0 - a2);

    // Add the three squares at full width
    assign sum_next = {2'b00, s01_reg} + {2'b00, s12_reg} + {2'b00, s20_reg};

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_diff_reg <= 1'b0;
            v_sq_reg   <= 1'b0;
            v_sum_reg  <= 1'b0;
        end
        else if (en)
        begin
            v_diff_reg <= valid;
            v_sq_reg   <= v_diff_reg;
            v_sum_reg  <= v_sq_reg;
        end
    end

    // Advance the payload: differences, then squares, then sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d01_reg <= d01_next;
            d12_reg <= d12_next;
            d20_reg <= d20_next;
            s01_reg <= d01_reg * d01_reg;
            s12_reg <= d12_reg * d12_reg;
            s20_reg <= d20_reg * d20_reg;
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = v_sum_reg;
    assign sum       = sum_reg;

endmodule

`default_nettype wire

// File: rtl/core/tpsp_sqrt_cell.sv
`default_nettype none

// One step of the digit-by-digit square root: settles one root bit.
module tpsp_sqrt_cell #(
    parameter int PIXEL_BITS = tpsp_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      valid_in,
    input  wire logic [2*PIXEL_BITS+1:0]   rad_in,
    input  wire logic [PIXEL_BITS+2:0]     rem_in,
    input  wire logic [PIXEL_BITS:0]       root_in,
    output logic                           valid_out,
    output logic [2*PIXEL_BITS+1:0]        rad_out,
    output logic [PIXEL_BITS+2:0]          rem_out,
    output logic [PIXEL_BITS:0]            root_out
);
    import tpsp_pkg::*;

    localparam int RB   = PIXEL_BITS + 1;
    localparam int RW   = 2 * RB;
    localparam int REMW = RB + 2;

    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    logic            fits;
    logic            valid_reg;
    logic [RW-1:0]   rad_next;
    logic [RW-1:0]   rad_reg;
    logic [REMW-1:0] rem_next;
    logic [REMW-1:0] rem_reg;
    logic [RB-1:0]   root_next;
    logic [RB-1:0]   root_reg;

    // Bring down the next two radicand bits and try the next root bit
    assign cur       = {rem_in[REMW-3:0], rad_in[RW-1:RW-2]};
    assign trial     = {root_in, 2'b01};
    assign fits      = (cur >= trial);
    assign rem_next  = fits ? (cur - trial) : cur;
    assign root_next = {root_in[RB-2:0], fits};
    assign rad_next  = {rad_in[RW-3:0], 2'b00};

    // Hand the valid mark on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Hand the partial root on to the neighbour
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/three_phase_section_pixel_top.sv
`default_nettype none

// Channel  | handshake            | words
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | phase0_pixel, phase1_pixel, phase2_pixel
// out      | out_valid / out_ready| section_pixel, clipped
//
// One word is taken per cycle while in_ready is high. The path runs through
// three front stages, one root cell per root bit (PIXEL_BITS + 1), one output.
// Each root cell hands its word on every cycle unless the chain is stalled.
// Reset clears every valid mark; the payload registers are not reset.
// A stalled output fills a one-word skid register; in_ready drops only then.
module three_phase_section_pixel_top #(
    parameter int PIXEL_BITS = tpsp_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tpsp_pkg::FIELD_BITS-1:0]    phase0_pixel,
    input  wire logic [tpsp_pkg::FIELD_BITS-1:0]    phase1_pixel,
    input  wire logic [tpsp_pkg::FIELD_BITS-1:0]    phase2_pixel,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [tpsp_pkg::FIELD_BITS-1:0]         section_pixel,
    output logic                                    clipped
);
    import tpsp_pkg::*;

    localparam int PB   = PIXEL_BITS;
    localparam int RB   = PIXEL_BITS + 1;
    localparam int RW   = 2 * RB;
    localparam int REMW = RB + 2;

    logic                  en;
    logic                  sum_valid;
    logic [RW-1:0]         sum;
    logic                  cv   [0:RB];
    logic [RW-1:0]         crad [0:RB];
    logic [REMW-1:0]       crem [0:RB];
    logic [RB-1:0]         croot[0:RB];
    logic                  fin_valid;
    logic [RB-1:0]         fin_root;
    logic                  fin_clip;
    logic [FIELD_BITS-1:0] fin_pixel;
    logic                  take_new;
    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] out_pixel_reg;
    logic                  out_clip_reg;
    logic                  skid_valid_reg;
    logic [FIELD_BITS-1:0] skid_pixel_reg;
    logic                  skid_clip_reg;

    // Whole chain advances unless the skid word is occupied
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    tpsp_diff_sq #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid    (in_valid),
        .p0       (phase0_pixel),
        .p1       (phase1_pixel),
        .p2       (phase2_pixel),
        .sum_valid(sum_valid),
        .sum      (sum)
    );

    // Seed the first root cell
    assign cv[0]    = sum_valid;
    assign crad[0]  = sum;
    assign crem[0]  = '0;
    assign croot[0] = '0;

    // Chain of root cells, one root bit each
    for (genvar i = 0; i < RB; i++)
    begin : g_cell
        tpsp_sqrt_cell #(
            .PIXEL_BITS(PIXEL_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .valid_in (cv[i]),
            .rad_in   (crad[i]),
            .rem_in   (crem[i]),
            .root_in  (croot[i]),
            .valid_out(cv[i+1]),
            .rad_out  (crad[i+1]),
            .rem_out  (crem[i+1]),
            .root_out (croot[i+1])
        );
    end

    // Saturate a root that needs the extra bit
    assign fin_valid = cv[RB];
    assign fin_root  = croot[RB];
    assign fin_clip  = fin_root[RB-1];
    assign fin_pixel = FIELD_BITS'(fin_clip ? {PB{1'b1}} : fin_root[PB-1:0]);
    assign take_new  = fin_valid && en;

    // Output word and skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || take_new;
            skid_valid_reg <= 1'b0;
        end
        else if (take_new)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_pixel_reg <= skid_pixel_reg;
                out_clip_reg  <= skid_clip_reg;
            end
            else
            begin
                out_pixel_reg <= fin_pixel;
                out_clip_reg  <= fin_clip;
            end
        end
        else if (take_new)
        begin
            skid_pixel_reg <= fin_pixel;
            skid_clip_reg  <= fin_clip;
        end
    end

    assign out_valid     = out_valid_reg;
    assign section_pixel = out_pixel_reg;
    assign clipped       = out_clip_reg;

endmodule

`default_nettype wire

// File: rtl/core/tpsp_checker.sv
`default_nettype none

`include "three_phase_section_pixel_top_assert.svh"

// Port-level checks on the sectioning block.
module tpsp_checker #(
    parameter int PIXEL_BITS = tpsp_pkg::PIXEL_BITS_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [tpsp_pkg::FIELD_BITS-1:0] section_pixel,
    input wire logic                            clipped
);
    import tpsp_pkg::*;

    localparam logic [FIELD_BITS:0] PIX_MAX = (FIELD_BITS + 1)'((1 << PIXEL_BITS) - 1);

    logic [FIELD_BITS:0] pix_wide;

    assign pix_wide = {1'b0, section_pixel};

    // A clipped word shows the pixel maximum
    `TPSP_ASSERT_NOW(a_clip_max, out_valid && clipped, pix_wide == PIX_MAX, "clipped word not at maximum")

    // No word exceeds the pixel range
    `TPSP_ASSERT_NOW(a_range, out_valid, pix_wide <= PIX_MAX, "section pixel beyond range")

    // Input stalls only behind a waiting output word
    `TPSP_ASSERT_NOW(a_ready, !in_ready, out_valid, "input stalled with output empty")

    // A stalled output word holds
    `TPSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(section_pixel) && $stable(clipped), "stalled output word changed")

endmodule

bind three_phase_section_pixel_top tpsp_checker #(
    .PIXEL_BITS(PIXEL_BITS)
) u_tpsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .section_pixel(section_pixel),
    .clipped      (clipped)
);

`default_nettype wire
